/* hdl/upd_pkg.sv */
// shared types, character constants and helper functions for the url path decoder
package upd_pkg;

  // characters the decoder looks for
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // most results a single item can produce
  localparam int unsigned MaxRes = 3;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_ESC   = 2'd1,
    ST_DOT_SEG   = 2'd2,
    ST_EMPTY_SEG = 2'd3
  } status_e;

  // one raw path byte as held in the input register
  typedef struct packed {
    logic [7:0] raw_byte;
    logic       has_byte;
    logic       last;
  } in_t;

  // decoder context carried from one item to the next
  typedef struct packed {
    phase_e      phase;
    logic [7:0]  held;
    logic        started;
    logic [23:0] recent;
    status_e     err;
  } state_t;

  // one result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_path;
    status_e    status;
  } res_t;

  typedef res_t [MaxRes-1:0] res_arr_t;

  // results of one item, handed from the decode step to the output queue
  typedef struct packed {
    res_arr_t   res;
    logic [1:0] nres;
  } step_out_t;

  // hex digit value, bit 4 set when the character is a hex digit
  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [4:0] v;
    v = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = {1'b1, c[3:0] + 4'd9};
    end
    return v;
  endfunction

  // keep the most important error: bad escape, then dot segment, then empty segment
  function automatic status_e note_err(status_e cur, status_e e);
    status_e r;
    r = cur;
    if (cur == ST_OK || e < cur) r = e;
    return r;
  endfunction

  // account for one emitted byte: segment checks and history shift
  function automatic state_t put_raw(state_t s, logic [7:0] b);
    state_t r;
    r = s;
    if (b == CH_SLASH) begin
      if (s.recent[7:0] == CH_SLASH) r.err = note_err(r.err, ST_EMPTY_SEG);
      if (s.recent[7:0] == CH_DOT && s.recent[15:8] == CH_SLASH)
        r.err = note_err(r.err, ST_DOT_SEG);
      if (s.recent[7:0] == CH_DOT && s.recent[15:8] == CH_DOT &&
          s.recent[23:16] == CH_SLASH)
        r.err = note_err(r.err, ST_DOT_SEG);
    end
    r.recent  = {s.recent[15:0], b};
    r.started = 1'b1;
    return r;
  endfunction

  // place a path byte into result slot n
  function automatic res_arr_t put_res(res_arr_t a, logic [1:0] n, logic [7:0] b);
    res_arr_t r;
    r = a;
    for (int k = 0; k < MaxRes; k++) begin
      if (n == 2'(k)) begin
        r[k].out_byte    = b;
        r[k].byte_valid  = 1'b1;
        r[k].end_of_path = 1'b0;
        r[k].status      = ST_OK;
      end
    end
    return r;
  endfunction

endpackage

/* hdl/upd_in_if.sv */
// raw path byte channel
interface upd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] raw_byte;
  logic       has_byte;
  logic       last;

  modport source (output valid, output raw_byte, output has_byte, output last, input ready);
  modport sink (input valid, input raw_byte, input has_byte, input last, output ready);
endinterface

/* hdl/upd_out_if.sv */
// decoded path byte channel
interface upd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       end_of_path;
  logic [1:0] status;

  modport source (output valid, output out_byte, output byte_valid, output end_of_path,
                  output status, input ready);
  modport sink (input valid, input out_byte, input byte_valid, input end_of_path,
                input status, output ready);
endinterface

/* hdl/url_path_decode_check.sv */
// top level of the streaming url path percent-decoder and checker
//
// in_i carries one raw path byte per item (raw_byte, has_byte, last); an
// empty path is a single item with has_byte low and last high. out_o carries
// the decoded path bytes; the final result of a path has end_of_path set and
// a status (ok, bad escape, dot segment, empty segment). On a bad escape the
// downstream discards what it already took of that path.
// An accepted item waits in the input register, is decoded combinationally
// and moves into the result register once that register is emptying; its
// results are then shown from the result register.
// Throughput is one item per cycle while each item yields at most one
// result and out_o is ready; an item with up to 3 results holds the result
// register until out_o, at one result per ready cycle, has taken them all.
// When out_o stalls, the result register holds and one more item is still
// taken into the input register before in_i ready drops.
// Reset clears the decoder context and empties the input register and the result
// register; the block takes items in the first cycle after reset.
module url_path_decode_check (
  input logic      clk_i,
  input logic      rst_ni,
  upd_in_if.sink   in_i,
  upd_out_if.source out_o
);
  import upd_pkg::*;

  in_t       in_q, in_d;
  logic      in_vld_q, in_vld_d;
  state_t    st_q, st_d, st_step;
  step_out_t step_res;
  res_t      head;
  logic      out_vld;
  logic      empty_next;
  logic      accept;
  logic      advance;

  // input register handshake
  assign advance    = in_vld_q && empty_next;
  assign in_i.ready = !in_vld_q || advance;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    in_d     = in_q;
    in_vld_d = in_vld_q;
    if (accept) begin
      in_d.raw_byte = in_i.raw_byte;
      in_d.has_byte = in_i.has_byte;
      in_d.last     = in_i.last;
      in_vld_d      = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
    st_d = advance ? st_step : st_q;
  end

  // decode logic
  upd_step u_step (
    .item_i (in_q),
    .st_i   (st_q),
    .st_o   (st_step),
    .res_o  (step_res)
  );

  // result register
  upd_outq u_outq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (advance),
    .step_i       (step_res),
    .pop_i        (out_o.ready),
    .head_o       (head),
    .valid_o      (out_vld),
    .empty_next_o (empty_next)
  );

  assign out_o.valid       = out_vld;
  assign out_o.out_byte    = head.out_byte;
  assign out_o.byte_valid  = head.byte_valid;
  assign out_o.end_of_path = head.end_of_path;
  assign out_o.status      = head.status;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      st_q     <= '0;
    end else begin
      in_vld_q <= in_vld_d;
      st_q     <= st_d;
    end
  end

  // input payload
  always_ff @(posedge clk_i) begin
    in_q <= in_d;
  end

  // a decoded item with results shows them on the next cycle
  a_load_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && step_res.nres != 2'd0 |=> out_o.valid)
    else $error("loaded results not visible");

  // the context is cleared after the last item of a path
  a_ctx_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_q.last |=> st_q == '0)
    else $error("decoder context not cleared at end of path");

  // a result without a path byte only ever closes a path
  a_empty_is_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.byte_valid |-> out_o.end_of_path)
    else $error("empty result without end mark");

  // status only on the final result
  a_status_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.end_of_path |-> out_o.status == ST_OK)
    else $error("status on a non-final result");

endmodule

/* hdl/upd_step.sv */
// decode step: one raw byte plus context in, up to three result items and new context out
module upd_step (
  input  upd_pkg::in_t       item_i,
  input  upd_pkg::state_t    st_i,
  output upd_pkg::state_t    st_o,
  output upd_pkg::step_out_t res_o
);
  import upd_pkg::*;

  state_t     s;
  res_arr_t   res;
  logic [1:0] n;
  logic [1:0] dec_v;
  logic [7:0] dec_b [2];
  logic [7:0] d;
  logic [7:0] plain_c;
  logic [7:0] plain_h;
  logic [4:0] hi;
  logic [4:0] lo;

  // literal bytes: plus maps to space
  assign plain_c = (item_i.raw_byte == CH_PLUS) ? CH_SPACE : item_i.raw_byte;
  assign plain_h = (st_i.held == CH_PLUS) ? CH_SPACE : st_i.held;
  assign hi      = hex_val(st_i.held);
  assign lo      = hex_val(item_i.raw_byte);

  always_comb begin
    s        = st_i;
    res      = '0;
    n        = '0;
    dec_v    = '0;
    dec_b[0] = '0;
    dec_b[1] = '0;
    d        = '0;

    // escape sequencing: pick up to two decoded bytes
    if (item_i.has_byte) begin
      case (st_i.phase)
        PH_PCT: begin
          if (item_i.last) begin
            dec_v    = 2'b11;
            dec_b[0] = CH_PCT;
            dec_b[1] = plain_c;
            s.phase  = PH_IDLE;
          end else begin
            s.held  = item_i.raw_byte;
            s.phase = PH_DIGIT;
          end
        end
        PH_DIGIT: begin
          s.phase = PH_IDLE;
          if (!hi[4] || !lo[4]) begin
            s.err = ST_BAD_ESC;
          end else begin
            dec_v[0] = 1'b1;
            dec_b[0] = {hi[3:0], lo[3:0]};
          end
        end
        default: begin
          if (item_i.raw_byte == CH_PCT && !item_i.last) begin
            s.phase = PH_PCT;
          end else begin
            dec_v[0] = 1'b1;
            dec_b[0] = plain_c;
          end
        end
      endcase
    end else if (item_i.last) begin
      // flush a pending escape as literals
      case (st_i.phase)
        PH_PCT: begin
          dec_v[0] = 1'b1;
          dec_b[0] = CH_PCT;
        end
        PH_DIGIT: begin
          dec_v    = 2'b11;
          dec_b[0] = CH_PCT;
          dec_b[1] = plain_h;
        end
        default: begin
          dec_v = '0;
        end
      endcase
      s.phase = PH_IDLE;
    end

    // emit decoded bytes with backslash mapping and leading slash
    for (int i = 0; i < 2; i++) begin
      if (dec_v[i] && s.err != ST_BAD_ESC) begin
        d = (dec_b[i] == CH_BSLASH) ? CH_SLASH : dec_b[i];
        if (!s.started && d != CH_SLASH) begin
          res = put_res(res, n, CH_SLASH);
          s   = put_raw(s, CH_SLASH);
          n   = n + 2'd1;
        end
        res = put_res(res, n, d);
        s   = put_raw(s, d);
        n   = n + 2'd1;
      end
    end

    // end of path: lone slash, trailing dot checks, end mark and status
    if (item_i.last) begin
      if (!s.started && s.err != ST_BAD_ESC) begin
        res = put_res(res, n, CH_SLASH);
        s   = put_raw(s, CH_SLASH);
        n   = n + 2'd1;
      end
      if (s.recent[15:0] == {CH_SLASH, CH_DOT}) s.err = note_err(s.err, ST_DOT_SEG);
      if (s.recent == {CH_SLASH, CH_DOT, CH_DOT}) s.err = note_err(s.err, ST_DOT_SEG);
      if (n == 2'd0) n = 2'd1;
      for (int k = 0; k < MaxRes; k++) begin
        if (n - 2'd1 == 2'(k)) begin
          res[k].end_of_path = 1'b1;
          res[k].status      = s.err;
        end
      end
      s = '0;
    end

    st_o      = s;
    res_o.res = res;
    res_o.nres = n;
  end

endmodule

/* hdl/upd_outq.sv */
// result register: holds an item's results and pops one per cycle on pop_i
module upd_outq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  upd_pkg::step_out_t step_i,
  input  logic               pop_i,
  output upd_pkg::res_t      head_o,
  output logic               valid_o,
  output logic               empty_next_o
);
  import upd_pkg::*;

  res_arr_t   ent_q, ent_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign valid_o      = (cnt_q != 2'd0);
  assign pop          = valid_o && pop_i;
  assign empty_next_o = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop_i);
  assign head_o       = ent_q[0];

  // load a fresh set or shift toward the head on a pop
  always_comb begin
    ent_d = ent_q;
    cnt_d = cnt_q;
    if (load_i) begin
      ent_d = step_i.res;
      cnt_d = step_i.nres;
    end else if (pop) begin
      for (int k = 0; k < MaxRes - 1; k++) ent_d[k] = ent_q[k+1];
      cnt_d = cnt_q - 2'd1;
    end
  end

  // occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule
